>>> rtl/core/volume_gradient_normalizer_top_macros.svh
// Assertion macros for the volume gradient normalizer.
// Used by the top level only; relies on clk_i and rst_ni being in scope.
`ifndef VOLUME_GRADIENT_NORMALIZER_TOP_MACROS_SVH
`define VOLUME_GRADIENT_NORMALIZER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VGN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gradient normalizer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VGN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gradient normalizer check failed");

`endif

>>> rtl/core/vgn_pkg.sv
// Shared types and constants of the volume gradient normalizer.
// No dependencies; imported by the normalizing unit and the top level.
package vgn_pkg;

  // Width of a dimension register and of the position counters.
  localparam int unsigned DIM_W   = 9;
  // Width of the configuration register index.
  localparam int unsigned CFG_IDX_W = 2;
  // Plane size w*h and result lag w*h+w+1, counted in voxels.
  localparam int unsigned PLANE_W = 2 * DIM_W;
  localparam int unsigned LAT_W   = PLANE_W + 1;
  // Sum of squares of three 9-bit differences.
  localparam int unsigned SUM_W   = 18;
  // Normalized magnitude, 0..16384.
  localparam int unsigned MAG_W   = 15;
  localparam int unsigned GRAD_W  = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 2'd2;

  // Input item kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  // Main sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RADDR,
    S_RDATA,
    S_SQ,
    S_NGO,
    S_NWAIT,
    S_EMIT
  } vgn_state_e;

  // Divide / square-root unit states.
  typedef enum logic [1:0] {
    U_IDLE,
    U_DIV,
    U_SQRT,
    U_DONE
  } vgn_ustate_e;

  // Request to the normalizing unit.
  typedef struct packed {
    logic               start;
    logic [7:0]         mag_in;
    logic [SUM_W-1:0]   sum_sq;
  } vgn_norm_req_t;

  // Response of the normalizing unit.
  typedef struct packed {
    logic               done;
    logic [MAG_W-1:0]   mag_out;
  } vgn_norm_rsp_t;

endpackage

>>> rtl/core/vgn_ring.sv
// Voxel ring store: one write port, one registered read port.
// Depends on nothing but its parameters.
module vgn_ring #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/core/vgn_norm_unit.sv
// Shared normalizing unit: round(16384 * a / sqrt(s)) by restoring division
// of a*a*2^30 by s, then a bit-pair integer square root. Uses vgn_pkg.
module vgn_norm_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  vgn_pkg::vgn_norm_req_t req_i,
  output vgn_pkg::vgn_norm_rsp_t rsp_o
);
  import vgn_pkg::*;

  localparam int unsigned QBITS = 31;

  vgn_ustate_e       state_q, state_d;
  logic [4:0]        cnt_q, cnt_d;
  logic              first_q, first_d;
  logic [18:0]       rem_q, rem_d;
  logic [31:0]       quo_q, quo_d;
  logic [15:0]       root_q, root_d;
  logic [SUM_W-1:0]  sum_q, sum_d;

  logic [18:0]       div_trial;
  logic              div_ge;
  logic [18:0]       sq_rem;
  logic [18:0]       sq_trial;
  logic              sq_ge;
  logic [16:0]       root_inc;

  // Datapath of one division or root step.
  always_comb begin
    div_trial = first_q ? rem_q : {rem_q[17:0], 1'b0};
    div_ge    = div_trial >= {1'b0, sum_q};
    sq_rem    = {rem_q[16:0], quo_q[31:30]};
    sq_trial  = {1'b0, root_q, 2'b01};
    sq_ge     = sq_rem >= sq_trial;
    root_inc  = {1'b0, root_q} + 17'd1;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      U_IDLE: if (req_i.start) state_d = U_DIV;
      U_DIV:  if (cnt_q == 5'(QBITS - 1)) state_d = U_SQRT;
      U_SQRT: if (cnt_q == 5'd15) state_d = U_DONE;
      U_DONE: state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  // Register updates per state.
  always_comb begin
    cnt_d   = cnt_q;
    first_d = first_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    root_d  = root_q;
    sum_d   = sum_q;
    case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          cnt_d   = '0;
          first_d = 1'b1;
          rem_d   = 19'(req_i.mag_in * req_i.mag_in);
          quo_d   = '0;
          sum_d   = req_i.sum_sq;
        end
      end
      U_DIV: begin
        first_d = 1'b0;
        rem_d   = div_ge ? div_trial - {1'b0, sum_q} : div_trial;
        quo_d   = {quo_q[30:0], div_ge};
        if (cnt_q == 5'(QBITS - 1)) begin
          cnt_d  = '0;
          rem_d  = '0;
          root_d = '0;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      U_SQRT: begin
        rem_d  = sq_ge ? sq_rem - sq_trial : sq_rem;
        root_d = {root_q[14:0], sq_ge};
        quo_d  = {quo_q[29:0], 2'b00};
        cnt_d  = cnt_q + 5'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    first_q <= first_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    root_q  <= root_d;
    sum_q   <= sum_d;
  end

  // Round half up on the root: (root + 1) / 2.
  assign rsp_o.done    = (state_q == U_DONE);
  assign rsp_o.mag_out = root_inc[MAG_W:1];

endmodule

>>> rtl/core/volume_gradient_normalizer_top.sv
// Volume gradient normalizer, top level.
// Uses vgn_pkg, vgn_ring, vgn_norm_unit and the assertion macro header.
//
// Voxels arrive in raster order (x fastest); each result is the central
// difference gradient of an earlier voxel, normalized to signed Q1.14, and
// trails its voxel by one plane, one row and one voxel. Flush requests after
// the last voxel drain the rest. A voxel that yields a result takes six
// neighbor reads from the single store read port, the sum of squares and,
// unless that sum is zero, 31 quotient steps and 16 root steps per component
// in the shared divide and square-root unit, which sets the rate. The block
// accepts no input request while it works. Writing a dimension register
// restarts the stream. The voxel store needs no clearing after reset.
`include "volume_gradient_normalizer_top_macros.svh"

module volume_gradient_normalizer_top #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned MAX_DEPTH  = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [vgn_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [vgn_pkg::DIM_W-1:0]            cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 kind_i,
  input  logic [7:0]                           sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [vgn_pkg::GRAD_W-1:0]    grad_x_o,
  output logic signed [vgn_pkg::GRAD_W-1:0]    grad_y_o,
  output logic signed [vgn_pkg::GRAD_W-1:0]    grad_z_o,
  output logic                                 last_voxel_o
);
  import vgn_pkg::*;

  localparam int unsigned RING = 2 * MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 2;
  localparam int unsigned AW   = $clog2(RING);

  // Configuration registers and effective dimensions.
  logic [DIM_W-1:0] width_q, height_q, depth_q;
  logic [DIM_W-1:0] ew, eh, ed;
  logic [PLANE_W-1:0] plane_q;
  logic [LAT_W-1:0]   lat;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input int unsigned mx);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (32'(v) > mx) r = DIM_W'(mx);
    else r = v;
    return r;
  endfunction

  always_comb begin
    ew  = eff_dim(width_q, MAX_WIDTH);
    eh  = eff_dim(height_q, MAX_HEIGHT);
    ed  = eff_dim(depth_q, MAX_DEPTH);
    lat = LAT_W'(plane_q) + LAT_W'(ew) + LAT_W'(1);
  end

  // Sequencer and stream state.
  vgn_state_e state_q, state_d;
  logic [DIM_W-1:0] ix_q, iy_q, iz_q, ox_q, oy_q, oz_q;
  logic             in_done_q, out_done_q;
  logic [AW-1:0]    wp_q, rp_q;
  logic [LAT_W-1:0] diff_q;
  logic [2:0]       k_q;
  logic [1:0]       c_q;
  logic signed [8:0] g_q [3];
  logic [SUM_W-1:0] s_q;
  logic signed [GRAD_W-1:0] res_q [3];
  logic             out_valid_q;
  logic signed [GRAD_W-1:0] ox_res_q, oy_res_q, oz_res_q;
  logic             last_q;

  // Handshake events.
  logic cfg_fire, in_fire, wr_en, flush_go, emit_fire, rd_en, restart;
  logic o_last;

  // Neighbor addressing for read k: component k/2, odd k is the previous one.
  logic [1:0]       nc;
  logic             nneg, nok;
  logic [AW:0]      noff, nsum, ndif;
  logic [AW-1:0]    naddr;
  logic [7:0]       rd_data;
  logic signed [17:0] sq;
  logic [7:0]       abs_g;
  vgn_norm_req_t    nreq;
  vgn_norm_rsp_t    nrsp;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign restart     = cfg_fire && (cfg_index_i == REG_WIDTH ||
                       cfg_index_i == REG_HEIGHT || cfg_index_i == REG_DEPTH);
  assign in_fire     = in_valid_i & in_ready_o;
  assign o_last      = (ox_q == ew - 1'b1) && (oy_q == eh - 1'b1) && (oz_q == ed - 1'b1);

  always_comb begin
    nc   = k_q[2:1];
    nneg = k_q[0];
    case (nc)
      2'd0: begin
        noff = (AW+1)'(1);
        nok  = nneg ? (ox_q != '0) : (ox_q != ew - 1'b1);
      end
      2'd1: begin
        noff = (AW+1)'(ew);
        nok  = nneg ? (oy_q != '0) : (oy_q != eh - 1'b1);
      end
      default: begin
        noff = (AW+1)'(plane_q);
        nok  = nneg ? (oz_q != '0) : (oz_q != ed - 1'b1);
      end
    endcase
    nsum = {1'b0, rp_q} + noff;
    if (nsum >= (AW+1)'(RING)) nsum = nsum - (AW+1)'(RING);
    if ({1'b0, rp_q} >= noff) ndif = {1'b0, rp_q} - noff;
    else ndif = {1'b0, rp_q} + (AW+1)'(RING) - noff;
    naddr = nneg ? ndif[AW-1:0] : nsum[AW-1:0];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (kind_i == KIND_SAMPLE && !in_done_q) state_d = S_CHECK;
          else if (kind_i == KIND_FLUSH && in_done_q && !out_done_q) state_d = S_RADDR;
        end
      end
      S_CHECK: state_d = (!out_done_q && diff_q > lat) ? S_RADDR : S_IDLE;
      S_RADDR: state_d = S_RDATA;
      S_RDATA: state_d = (k_q == 3'd5) ? S_SQ : S_RADDR;
      S_SQ: begin
        if (c_q == 2'd2) state_d = (s_q + unsigned'(sq) == '0) ? S_EMIT : S_NGO;
      end
      S_NGO: state_d = S_NWAIT;
      S_NWAIT: begin
        if (nrsp.done) state_d = (c_q == 2'd2) ? S_EMIT : S_NGO;
      end
      S_EMIT: if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    wr_en      = 1'b0;
    flush_go   = 1'b0;
    rd_en      = (state_q == S_RADDR);
    emit_fire  = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
    if (state_q == S_IDLE && in_fire) begin
      wr_en    = (kind_i == KIND_SAMPLE) && !in_done_q;
      flush_go = (kind_i == KIND_FLUSH) && in_done_q && !out_done_q;
    end
  end

  // Square of the selected component and its magnitude.
  always_comb begin
    sq    = g_q[c_q] * g_q[c_q];
    abs_g = g_q[c_q][8] ? 8'(-g_q[c_q]) : g_q[c_q][7:0];
    nreq.start  = (state_q == S_NGO);
    nreq.mag_in = abs_g;
    nreq.sum_sq = s_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= DIM_W'(256);
      height_q    <= DIM_W'(256);
      depth_q     <= DIM_W'(256);
      ix_q <= '0; iy_q <= '0; iz_q <= '0;
      ox_q <= '0; oy_q <= '0; oz_q <= '0;
      in_done_q   <= 1'b0;
      out_done_q  <= 1'b0;
      wp_q        <= '0;
      rp_q        <= '0;
      diff_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Dimension register writes restart the stream.
      if (cfg_fire) begin
        case (cfg_index_i)
          REG_WIDTH:  width_q  <= cfg_data_i;
          REG_HEIGHT: height_q <= cfg_data_i;
          REG_DEPTH:  depth_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (restart) begin
        ix_q <= '0; iy_q <= '0; iz_q <= '0;
        ox_q <= '0; oy_q <= '0; oz_q <= '0;
        in_done_q  <= 1'b0;
        out_done_q <= 1'b0;
        wp_q       <= '0;
        rp_q       <= '0;
        diff_q     <= '0;
      end else if (wr_en) begin
        // Advance the input position and write pointer.
        wp_q   <= (wp_q == AW'(RING - 1)) ? '0 : wp_q + 1'b1;
        diff_q <= diff_q + 1'b1;
        if (ix_q == ew - 1'b1) begin
          ix_q <= '0;
          if (iy_q == eh - 1'b1) begin
            iy_q <= '0;
            if (iz_q == ed - 1'b1) in_done_q <= 1'b1;
            else iz_q <= iz_q + 1'b1;
          end else begin
            iy_q <= iy_q + 1'b1;
          end
        end else begin
          ix_q <= ix_q + 1'b1;
        end
      end else if (emit_fire) begin
        // Advance the output position and read pointer.
        rp_q   <= (rp_q == AW'(RING - 1)) ? '0 : rp_q + 1'b1;
        diff_q <= diff_q - 1'b1;
        if (o_last) out_done_q <= 1'b1;
        if (ox_q == ew - 1'b1) begin
          ox_q <= '0;
          if (oy_q == eh - 1'b1) begin
            oy_q <= '0;
            if (oz_q != ed - 1'b1) oz_q <= oz_q + 1'b1;
          end else begin
            oy_q <= oy_q + 1'b1;
          end
        end else begin
          ox_q <= ox_q + 1'b1;
        end
      end
      // Output register handshake.
      if (emit_fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    plane_q <= PLANE_W'(ew * eh);
    if ((state_q == S_CHECK && state_d == S_RADDR) || flush_go) begin
      k_q    <= '0;
      g_q[0] <= '0;
      g_q[1] <= '0;
      g_q[2] <= '0;
    end
    // Accumulate neighbor differences.
    if (state_q == S_RDATA) begin
      if (nok) begin
        g_q[nc] <= nneg ? g_q[nc] - $signed({1'b0, rd_data})
                        : g_q[nc] + $signed({1'b0, rd_data});
      end
      k_q <= k_q + 3'd1;
      c_q <= '0;
      s_q <= '0;
    end
    // Sum of squares, one component a cycle.
    if (state_q == S_SQ) begin
      s_q <= s_q + unsigned'(sq);
      if (c_q == 2'd2) begin
        c_q      <= '0;
        res_q[0] <= '0;
        res_q[1] <= '0;
        res_q[2] <= '0;
      end else begin
        c_q <= c_q + 2'd1;
      end
    end
    // Signed normalized component from the shared unit.
    if (state_q == S_NWAIT && nrsp.done) begin
      res_q[c_q] <= g_q[c_q][8] ? -$signed({1'b0, nrsp.mag_out})
                                : $signed({1'b0, nrsp.mag_out});
      c_q <= c_q + 2'd1;
    end
    if (emit_fire) begin
      ox_res_q <= res_q[0];
      oy_res_q <= res_q[1];
      oz_res_q <= res_q[2];
      last_q   <= o_last;
    end
  end

  vgn_ring #(
    .DEPTH (RING),
    .AW    (AW)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wp_q),
    .wr_data_i (sample_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (naddr),
    .rd_data_o (rd_data)
  );

  vgn_norm_unit u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (nreq),
    .rsp_o  (nrsp)
  );

  assign out_valid_o  = out_valid_q;
  assign grad_x_o     = ox_res_q;
  assign grad_y_o     = oy_res_q;
  assign grad_z_o     = oz_res_q;
  assign last_voxel_o = last_q;

  // The shared unit only finishes while the sequencer waits for it.
  `VGN_ASSERT_IMP(a_norm_done_wait, nrsp.done, state_q == S_NWAIT)
  // No result is produced once the last voxel has been given out.
  `VGN_ASSERT_IMP(a_no_emit_after_last, emit_fire, !out_done_q)
  // Outstanding voxels never exceed the latency plus the one just written.
  `VGN_ASSERT_NXT(a_diff_bound, state_q == S_CHECK && !restart, diff_q <= lat + 1'b1)

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the volume gradient normalizer.
// Depends on vgn_pkg and volume_gradient_normalizer_top; predicts normalized
// central difference gradients and checks every result against them.
`timescale 1ns / 100ps

module tb_top;
  import vgn_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned SETTLE_CYCLES = 400;
  localparam int unsigned STALL_LIMIT  = 40000;

  typedef struct {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic signed [GRAD_W-1:0] gz;
    logic                     last;
  } grad_t;

  // Predicts the gradient stream and compares the block's results with it.
  class gradient_scoreboard;
    int unsigned dim_reg[3];
    int unsigned pos_x, pos_y, pos_z, next_out;
    byte unsigned voxels[int unsigned];
    grad_t expected_grads[$];
    int unsigned errors;

    function void reset_state();
      dim_reg = '{256, 256, 256};
      restart();
    endfunction

    function void restart();
      pos_x = 0;
      pos_y = 0;
      pos_z = 0;
      next_out = 0;
      voxels.delete();
    endfunction

    function void write_dim(int unsigned idx, int unsigned value);
      dim_reg[idx] = value & 9'h1ff;
      restart();
    endfunction

    // Ties round away from zero; s > 0 and d*d <= s.
    function int norm_comp(int d, longint unsigned s);
      longint unsigned ad, rhs, t;
      int unsigned lo, hi, mid;
      ad = (d < 0) ? -d : d;
      rhs = (ad * ad) << 30;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        t = 2 * mid - 1;
        if (t * t * s <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return (d < 0) ? -int'(lo) : int'(lo);
    endfunction

    function void push_result(int unsigned v, int unsigned w, int unsigned h,
                              int unsigned dp);
      int unsigned plane, x, y, z;
      int gx, gy, gz;
      longint unsigned s;
      grad_t r;
      plane = w * h;
      x = v % w;
      y = (v / w) % h;
      z = v / plane;
      gx = 0;
      gy = 0;
      gz = 0;
      if (x + 1 < w) gx += voxels[v + 1];
      if (x > 0) gx -= voxels[v - 1];
      if (y + 1 < h) gy += voxels[v + w];
      if (y > 0) gy -= voxels[v - w];
      if (z + 1 < dp) gz += voxels[v + plane];
      if (z > 0) gz -= voxels[v - plane];
      s = gx * gx + gy * gy + gz * gz;
      if (s == 0) begin
        r.gx = 0;
        r.gy = 0;
        r.gz = 0;
      end else begin
        r.gx = norm_comp(gx, s);
        r.gy = norm_comp(gy, s);
        r.gz = norm_comp(gz, s);
      end
      r.last = (v + 1 == plane * dp);
      expected_grads.push_back(r);
    endfunction

    // Called for every accepted input request.
    function void note_input(logic kind, logic [7:0] sample);
      int unsigned w, h, dp, total, lat, count;
      w = eff_dim(dim_reg[0]);
      h = eff_dim(dim_reg[1]);
      dp = eff_dim(dim_reg[2]);
      total = w * h * dp;
      lat = w * h + w + 1;
      count = (pos_z * h + pos_y) * w + pos_x;
      if (kind == KIND_SAMPLE) begin
        if (count >= total) return;
        voxels[count] = sample;
        count++;
        pos_x++;
        if (pos_x >= w) begin
          pos_x = 0;
          pos_y++;
          if (pos_y >= h) begin
            pos_y = 0;
            pos_z++;
          end
        end
        if (next_out < total && next_out + lat < count) begin
          push_result(next_out, w, h, dp);
          next_out++;
        end
      end else if (count == total && next_out < total) begin
        push_result(next_out, w, h, dp);
        next_out++;
      end
    endfunction

    // Called for every accepted result.
    function void check_result(grad_t act);
      grad_t exp_r;
      if (expected_grads.size() == 0) begin
        $error("unexpected result: grad_x %0d grad_y %0d grad_z %0d",
               act.gx, act.gy, act.gz);
        errors++;
        return;
      end
      exp_r = expected_grads.pop_front();
      if (act.gx !== exp_r.gx) begin
        $error("grad_x mismatch: expected %0d, actual %0d", exp_r.gx, act.gx);
        errors++;
      end
      if (act.gy !== exp_r.gy) begin
        $error("grad_y mismatch: expected %0d, actual %0d", exp_r.gy, act.gy);
        errors++;
      end
      if (act.gz !== exp_r.gz) begin
        $error("grad_z mismatch: expected %0d, actual %0d", exp_r.gz, act.gz);
        errors++;
      end
      if (act.last !== exp_r.last) begin
        $error("last_voxel mismatch: expected %0d, actual %0d", exp_r.last, act.last);
        errors++;
      end
    endfunction
  endclass

  function automatic int unsigned eff_dim(int unsigned v);
    if (v < 1) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = KIND_SAMPLE;
  logic [7:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [GRAD_W-1:0] grad_x, grad_y, grad_z;
  logic last_voxel;

  gradient_scoreboard sb = new();
  int unsigned send_idle_pct = 37;
  int unsigned recv_stall_pct = 81;
  bit hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned random_items = 0;

  volume_gradient_normalizer_top uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(kind), .sample_i(sample),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .grad_x_o(grad_x), .grad_y_o(grad_y), .grad_z_o(grad_z),
    .last_voxel_o(last_voxel)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_req = 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    grad_t r;
    if (rst_n && out_valid && out_ready) begin
      r.gx = grad_x;
      r.gy = grad_y;
      r.gz = grad_z;
      r.last = last_voxel;
      sb.check_result(r);
    end
  end

  // Watchdog on cycles without any accepted request.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Writes one dimension register; called at a falling edge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_dim(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Offers one input request and waits for it to be taken.
  task automatic send_item(logic k, logic [7:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    kind = k;
    sample = s;
    do @(posedge clk); while (!in_ready);
    sb.note_input(k, s);
    @(negedge clk);
  endtask

  // Waits until every expected result is in, then lets the block settle.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.expected_grads.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Sends a whole volume with optional noise: early flushes, extra voxels.
  // Pattern: 0 random, 1 constant, 2 extremes only.
  task automatic run_volume(int unsigned w, int unsigned h, int unsigned dp,
                            int unsigned pattern, bit noise);
    int unsigned total, lat, flushes;
    logic [7:0] level;
    logic [7:0] s;
    write_reg(REG_DEPTH, dp);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    total = eff_dim(w) * eff_dim(h) * eff_dim(dp);
    lat = eff_dim(w) * eff_dim(h) + eff_dim(w) + 1;
    flushes = (total < lat) ? total : lat;
    level = $urandom;
    if (noise) send_item(KIND_FLUSH, $urandom);
    for (int unsigned i = 0; i < total; i++) begin
      case (pattern)
        0: s = $urandom;
        1: s = level;
        default: s = $urandom_range(1) ? 8'hff : 8'h00;
      endcase
      send_item(KIND_SAMPLE, s);
      if (noise && $urandom_range(15) == 0) send_item(KIND_FLUSH, $urandom);
    end
    if (noise) send_item(KIND_SAMPLE, $urandom);
    for (int unsigned i = 0; i < flushes; i++) send_item(KIND_FLUSH, $urandom);
    if (noise) begin
      send_item(KIND_FLUSH, $urandom);
      send_item(KIND_SAMPLE, $urandom);
    end
    random_items += total + flushes;
    drain();
  endtask

  initial begin
    int unsigned phase;
    sb.reset_state();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: extremes, constant volume, all dimension extremes.
    run_volume(2, 2, 2, 2, 1'b1);
    run_volume(3, 2, 2, 1, 1'b1);
    run_volume(0, 0, 0, 0, 1'b1);
    run_volume(511, 1, 1, 0, 1'b0);
    run_volume(1, 300, 1, 2, 1'b0);
    run_volume(2, 1, 256, 0, 1'b0);
    random_items = 0;

    // Random volumes, long receiver hold-off in the first of them.
    phase = 0;
    while (random_items < 900) begin
      if (random_items >= 600) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else if (random_items >= 300) begin
        send_idle_pct = 81;
        recv_stall_pct = 37;
      end
      if (phase == 0) hold_req = 1'b1;
      run_volume($urandom_range(6, 1), $urandom_range(5, 1), $urandom_range(5, 1),
                 ($urandom_range(9) == 0) ? 1 : ($urandom_range(5) == 0 ? 2 : 0),
                 $urandom_range(3) == 0);
      phase++;
    end

    if (sb.errors == 0 && sb.expected_grads.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/vgn_pkg.sv
rtl/core/vgn_ring.sv
rtl/core/vgn_norm_unit.sv
rtl/core/volume_gradient_normalizer_top.sv
tb/tb_top.sv
